/* hdl/bba_pkg.sv */
package bba_pkg;

  localparam int unsigned DefMaxLevels = 10;
  localparam logic [31:0] DefPoolBase  = 32'd0;
  localparam logic [31:0] DefPoolSize  = 32'd1048576;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegPoolBase = 1'b0;
  localparam logic [CfgIdxW-1:0] RegPoolSize = 1'b1;

  typedef enum logic [1:0] {
    NODE_ABSENT = 2'd0,
    NODE_FREE   = 2'd1,
    NODE_TAKEN  = 2'd2,
    NODE_SPLIT  = 2'd3
  } node_st_e;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_BAD_SIZE  = 2'd1,
    STAT_NO_FIT    = 2'd2,
    STAT_NOT_ALLOC = 2'd3
  } status_e;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_S1,
    ST_S2,
    ST_BACK,
    ST_MG,
    ST_ML,
    ST_MR,
    ST_MW1,
    ST_MW2,
    ST_MW3,
    ST_DONE
  } fsm_e;

  typedef struct packed {
    logic        valid;
    logic [1:0]  status;
    logic [31:0] granted_address;
  } bba_res_t;

endpackage

/* hdl/bba_req_if.sv */
interface bba_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] request_size;
  logic [31:0] block_address;

  modport source (output valid, kind, request_size, block_address, input ready);
  modport sink (input valid, kind, request_size, block_address, output ready);
endinterface

/* hdl/bba_rsp_if.sv */
interface bba_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] granted_address;

  modport source (output valid, status, granted_address, input ready);
  modport sink (input valid, status, granted_address, output ready);
endinterface

/* hdl/bba_ram.sv */
module bba_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 2047
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/bba_ctrl.sv */
module bba_ctrl #(
  parameter int unsigned MaxLevels = bba_pkg::DefMaxLevels,
  localparam int unsigned IdxW = MaxLevels + 1,
  localparam int unsigned LvlW = $clog2(MaxLevels + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        pool_base_i,
  input  logic [31:0]        pool_size_i,
  input  logic               in_valid_i,
  input  logic               in_kind_i,
  input  logic [31:0]        in_size_i,
  input  logic [31:0]        in_addr_i,
  output logic               in_ready_o,
  input  logic               out_free_i,
  output bba_pkg::bba_res_t  res_o,
  output logic               ram_we_o,
  output logic [IdxW-1:0]    ram_addr_o,
  output logic [1:0]         ram_wdata_o,
  input  logic [1:0]         ram_rdata_i
);
  import bba_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'((2 << MaxLevels) - 2);
  localparam logic [LvlW-1:0] TopLvl  = LvlW'(MaxLevels);

  fsm_e             state_q, state_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [LvlW-1:0]  lvl_q, lvl_d;
  logic [31:0]      off_q, off_d;
  logic             kind_q, kind_d;
  logic [31:0]      req_q, req_d;
  logic [31:0]      addr_q, addr_d;
  logic [1:0]       stat_q, stat_d;
  logic [31:0]      gaddr_q, gaddr_d;
  logic [1:0]       stl_q, stl_d;

  logic [31:0]      size;
  logic [31:0]      half;
  logic             at_top;
  logic [IdxW-1:0]  lchild;
  logic [IdxW-1:0]  parent;
  logic [IdxW-1:0]  left_sib;
  logic             accept;
  logic             hit_alloc;
  logic             desc_alloc;
  logic             hit_free;
  logic             desc_free;

  // node geometry
  assign size     = pool_size_i >> lvl_q;
  assign half     = size >> 1;
  assign at_top   = (lvl_q == TopLvl);
  assign lchild   = {idx_q[IdxW-2:0], 1'b1};
  assign parent   = (idx_q - IdxW'(1)) >> 1;
  assign left_sib = {parent[IdxW-2:0], 1'b1};
  assign accept   = in_valid_i && in_ready_o;

  // search decisions on the fetched node
  assign hit_alloc  = (ram_rdata_i == NODE_FREE) && (size >= req_q) && ((half < req_q) || at_top);
  assign desc_alloc = !(size < req_q) && !at_top &&
                      ((ram_rdata_i == NODE_FREE) || (ram_rdata_i == NODE_SPLIT));
  assign hit_free   = (ram_rdata_i == NODE_TAKEN) && ((pool_base_i + off_q) == addr_q);
  assign desc_free  = (ram_rdata_i == NODE_SPLIT) && !at_top;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (idx_q == LastIdx) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (in_kind_i == KIND_ALLOC && (in_size_i == '0 || in_size_i >= pool_size_i)) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_RD: state_d = ST_EV;
      ST_EV: begin
        if (kind_q == KIND_ALLOC) begin
          if (hit_alloc) state_d = ST_DONE;
          else if (desc_alloc && ram_rdata_i == NODE_FREE) state_d = ST_S1;
          else if (desc_alloc) state_d = ST_RD;
          else state_d = ST_BACK;
        end else begin
          if (hit_free) state_d = ST_MG;
          else if (desc_free) state_d = ST_RD;
          else state_d = ST_BACK;
        end
      end
      ST_S1: state_d = ST_S2;
      ST_S2: state_d = ST_RD;
      ST_BACK: begin
        if (idx_q == '0) state_d = ST_DONE;
        else if (idx_q[0]) state_d = ST_RD;
      end
      ST_MG: state_d = (idx_q == '0) ? ST_DONE : ST_ML;
      ST_ML: state_d = ST_MR;
      ST_MR: begin
        if (stl_q == NODE_FREE && ram_rdata_i == NODE_FREE) state_d = ST_MW1;
        else state_d = ST_DONE;
      end
      ST_MW1: state_d = ST_MW2;
      ST_MW2: state_d = ST_MW3;
      ST_MW3: state_d = ST_MG;
      ST_DONE: if (out_free_i) state_d = ST_IDLE;
      default: state_d = ST_CLEAR;
    endcase
    if (cfg_we_i) state_d = ST_CLEAR;
  end

  // datapath and memory control
  always_comb begin
    idx_d       = idx_q;
    lvl_d       = lvl_q;
    off_d       = off_q;
    kind_d      = kind_q;
    req_d       = req_q;
    addr_d      = addr_q;
    stat_d      = stat_q;
    gaddr_d     = gaddr_q;
    stl_d       = stl_q;
    ram_we_o    = 1'b0;
    ram_addr_o  = idx_q;
    ram_wdata_o = NODE_ABSENT;
    in_ready_o  = (state_q == ST_IDLE);
    res_o       = '{valid: (state_q == ST_DONE) && out_free_i,
                    status: stat_q, granted_address: gaddr_q};
    unique case (state_q)
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = (idx_q == '0) ? NODE_FREE : NODE_ABSENT;
        idx_d       = idx_q + IdxW'(1);
      end
      ST_IDLE: begin
        kind_d  = in_kind_i;
        req_d   = in_size_i;
        addr_d  = in_addr_i;
        idx_d   = '0;
        lvl_d   = '0;
        off_d   = '0;
        stat_d  = STAT_BAD_SIZE;
        gaddr_d = '0;
      end
      ST_EV: begin
        if (kind_q == KIND_ALLOC) begin
          if (hit_alloc) begin
            ram_we_o    = 1'b1;
            ram_wdata_o = NODE_TAKEN;
            stat_d      = STAT_DONE;
            gaddr_d     = pool_base_i + off_q;
          end else if (desc_alloc && ram_rdata_i == NODE_FREE) begin
            ram_we_o    = 1'b1;
            ram_wdata_o = NODE_SPLIT;
          end else if (desc_alloc) begin
            idx_d = lchild;
            lvl_d = lvl_q + LvlW'(1);
          end
        end else begin
          if (hit_free) begin
            ram_we_o    = 1'b1;
            ram_wdata_o = NODE_FREE;
            stat_d      = STAT_DONE;
          end else if (desc_free) begin
            idx_d = lchild;
            lvl_d = lvl_q + LvlW'(1);
          end
        end
      end
      ST_S1: begin
        ram_we_o    = 1'b1;
        ram_addr_o  = lchild;
        ram_wdata_o = NODE_FREE;
      end
      ST_S2: begin
        ram_we_o    = 1'b1;
        ram_addr_o  = lchild + IdxW'(1);
        ram_wdata_o = NODE_FREE;
        idx_d       = lchild;
        lvl_d       = lvl_q + LvlW'(1);
      end
      // one level of backtracking per cycle
      ST_BACK: begin
        if (idx_q == '0) begin
          stat_d = (kind_q == KIND_ALLOC) ? STAT_NO_FIT : STAT_NOT_ALLOC;
        end else if (idx_q[0]) begin
          idx_d = idx_q + IdxW'(1);
          off_d = off_q + size;
        end else begin
          idx_d = parent;
          off_d = off_q - size;
          lvl_d = lvl_q - LvlW'(1);
        end
      end
      // buddy merge: read both children of the parent, then collapse
      ST_MG: ram_addr_o = left_sib;
      ST_ML: begin
        stl_d      = ram_rdata_i;
        ram_addr_o = left_sib + IdxW'(1);
      end
      ST_MW1: begin
        ram_we_o    = 1'b1;
        ram_addr_o  = left_sib;
        ram_wdata_o = NODE_ABSENT;
      end
      ST_MW2: begin
        ram_we_o    = 1'b1;
        ram_addr_o  = left_sib + IdxW'(1);
        ram_wdata_o = NODE_ABSENT;
        idx_d       = parent;
      end
      // merged parent becomes free
      ST_MW3: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = NODE_FREE;
      end
      default: ;
    endcase
    if (state_q == ST_MG && idx_q != '0) ram_addr_o = left_sib;
    if (state_q == ST_MW2) ram_addr_o = left_sib + IdxW'(1);
    if (cfg_we_i) idx_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      idx_q   <= '0;
      lvl_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      lvl_q   <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q   <= off_d;
    kind_q  <= kind_d;
    req_q   <= req_d;
    addr_q  <= addr_d;
    stat_q  <= stat_d;
    gaddr_q <= gaddr_d;
    stl_q   <= stl_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) lvl_q <= TopLvl)
    else $error("level beyond depth limit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !ram_we_o)
    else $error("node memory written while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EV && idx_q == '0) |-> (off_q == '0 && lvl_q == '0))
    else $error("root visited with nonzero offset or level");

endmodule

/* hdl/buddy_block_allocator_unit.sv */
// channel   dir   signals
// req_i     in    valid ready kind request_size block_address
// rsp_o     out   valid ready status granted_address
// cfg       in    cfg_we_i cfg_idx_i cfg_wdata_i
//
// requests are handled one at a time; each node visit is a
// read of the single-port node memory plus up to three writes for a split;
// a search backtracks a level at a time on a miss, and a free then merges buddies
// upward; after reset or a config write the node memory is cleared, all
// 2^(MAX_LEVELS+1)-1 nodes (2047 by default), during which no item is taken
// the result sits in an output register; a new request is taken while it waits
module buddy_block_allocator_unit #(
  parameter int unsigned MAX_LEVELS = bba_pkg::DefMaxLevels
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bba_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]                  cfg_wdata_i,
  bba_req_if.sink                      req_i,
  bba_rsp_if.source                    rsp_o
);
  import bba_pkg::*;

  localparam int unsigned NodeCount = (2 << MAX_LEVELS) - 1;
  localparam int unsigned IdxW      = MAX_LEVELS + 1;

  logic [31:0]     pool_base_q;
  logic [31:0]     pool_size_q;
  logic            out_valid_q;
  logic [1:0]      out_status_q;
  logic [31:0]     out_gaddr_q;
  bba_res_t        res;
  logic            out_free;
  logic            ram_we;
  logic [IdxW-1:0] ram_addr;
  logic [1:0]      ram_wdata;
  logic [1:0]      ram_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= DefPoolBase;
      pool_size_q <= DefPoolSize;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPoolBase: pool_base_q <= cfg_wdata_i;
        RegPoolSize: pool_size_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  bba_ram #(.Width(2), .Depth(NodeCount)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  bba_ctrl #(.MaxLevels(MAX_LEVELS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .pool_base_i (pool_base_q),
    .pool_size_i (pool_size_q),
    .in_valid_i  (req_i.valid),
    .in_kind_i   (req_i.kind),
    .in_size_i   (req_i.request_size),
    .in_addr_i   (req_i.block_address),
    .in_ready_o  (req_i.ready),
    .out_free_i  (out_free),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  // output register
  assign out_free = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res.valid) begin
      out_status_q <= res.status;
      out_gaddr_q  <= res.granted_address;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.granted_address = out_gaddr_q;

endmodule

/* test/tb_buddy_block_allocator_unit.sv */
module tb_buddy_block_allocator_unit;
  import bba_pkg::*;

  localparam int unsigned Levels = DefMaxLevels;
  localparam int unsigned Nodes  = (2 << Levels) - 1;

  typedef struct {
    kind_e       kind;
    logic [31:0] size;
    logic [31:0] addr;
  } request_t;

  typedef struct {
    status_e     status;
    logic [31:0] addr;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;

  bba_req_if req_if ();
  bba_rsp_if rsp_if ();

  buddy_block_allocator_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // allocator mirror
  logic [31:0] mir_base;
  logic [31:0] mir_size;
  node_st_e    mir_node [Nodes];
  logic [31:0] live_blocks [$];

  request_t pending_reqs [$];
  outcome_t expected_rsps [$];

  int unsigned mismatches = 0;
  int unsigned n_alloc_ok = 0, n_free_ok = 0, n_bad = 0, n_nofit = 0, n_unknown = 0;
  int unsigned n_checked = 0;

  function automatic void tree_clear();
    for (int i = 0; i < Nodes; i++) mir_node[i] = NODE_ABSENT;
    mir_node[0] = NODE_FREE;
    live_blocks.delete();
  endfunction

  // leftmost fitting node, splitting free nodes on the way down (preorder walk)
  function automatic bit find_fit(input logic [31:0] want, output int hit,
                                  output logic [31:0] hit_off);
    int          s_idx [$];
    int          s_lvl [$];
    logic [31:0] s_off [$];
    int          idx;
    int          lvl;
    logic [31:0] off;
    logic [31:0] sz;
    node_st_e    st;
    s_idx.push_back(0); s_lvl.push_back(0); s_off.push_back(0);
    hit = 0;
    hit_off = 0;
    while (s_idx.size() > 0) begin
      idx = s_idx.pop_back(); lvl = s_lvl.pop_back(); off = s_off.pop_back();
      if (idx >= Nodes || lvl > Levels) continue;
      sz = mir_size >> lvl;
      st = mir_node[idx];
      if (st == NODE_FREE && sz >= want && ((sz >> 1) < want || lvl >= Levels)) begin
        hit = idx;
        hit_off = off;
        return 1'b1;
      end
      if (sz < want || st == NODE_TAKEN || st == NODE_ABSENT) continue;
      if (lvl >= Levels || 2 * idx + 2 >= Nodes) continue;
      if (st == NODE_FREE) begin
        mir_node[2*idx+1] = NODE_FREE;
        mir_node[2*idx+2] = NODE_FREE;
        mir_node[idx] = NODE_SPLIT;
      end
      s_idx.push_back(2*idx+2); s_lvl.push_back(lvl+1); s_off.push_back(off + (sz >> 1));
      s_idx.push_back(2*idx+1); s_lvl.push_back(lvl+1); s_off.push_back(off);
    end
    return 1'b0;
  endfunction

  // taken node whose absolute address matches
  function automatic bit find_taken(input logic [31:0] where, output int hit);
    int          s_idx [$];
    int          s_lvl [$];
    logic [31:0] s_off [$];
    int          idx;
    int          lvl;
    logic [31:0] off;
    logic [31:0] sz;
    s_idx.push_back(0); s_lvl.push_back(0); s_off.push_back(0);
    hit = 0;
    while (s_idx.size() > 0) begin
      idx = s_idx.pop_back(); lvl = s_lvl.pop_back(); off = s_off.pop_back();
      if (idx >= Nodes || lvl > Levels) continue;
      if (mir_node[idx] == NODE_TAKEN) begin
        if (mir_base + off == where) begin
          hit = idx;
          return 1'b1;
        end
        continue;
      end
      if (mir_node[idx] != NODE_SPLIT || lvl >= Levels || 2 * idx + 2 >= Nodes) continue;
      sz = mir_size >> lvl;
      s_idx.push_back(2*idx+2); s_lvl.push_back(lvl+1); s_off.push_back(off + (sz >> 1));
      s_idx.push_back(2*idx+1); s_lvl.push_back(lvl+1); s_off.push_back(off);
    end
    return 1'b0;
  endfunction

  function automatic outcome_t allocator_step(request_t r);
    outcome_t    o;
    int          idx;
    int          p;
    logic [31:0] off;
    o.status = STAT_DONE;
    o.addr = 0;
    if (r.kind == KIND_ALLOC) begin
      if (r.size == 0 || r.size >= mir_size) begin
        o.status = STAT_BAD_SIZE;
        n_bad++;
      end else if (!find_fit(r.size, idx, off)) begin
        o.status = STAT_NO_FIT;
        n_nofit++;
      end else begin
        mir_node[idx] = NODE_TAKEN;
        o.addr = mir_base + off;
        live_blocks.push_back(o.addr);
        n_alloc_ok++;
      end
      return o;
    end
    if (!find_taken(r.addr, idx)) begin
      o.status = STAT_NOT_ALLOC;
      n_unknown++;
      return o;
    end
    n_free_ok++;
    foreach (live_blocks[i]) begin
      if (live_blocks[i] == r.addr) begin
        live_blocks.delete(i);
        break;
      end
    end
    mir_node[idx] = NODE_FREE;
    // merge buddies upward
    while (idx > 0) begin
      p = (idx - 1) / 2;
      if (mir_node[2*p+1] == NODE_FREE && mir_node[2*p+2] == NODE_FREE) begin
        mir_node[2*p+1] = NODE_ABSENT;
        mir_node[2*p+2] = NODE_ABSENT;
        mir_node[p] = NODE_FREE;
        idx = p;
      end else begin
        break;
      end
    end
    return o;
  endfunction

  task automatic issue(kind_e k, logic [31:0] sz, logic [31:0] ad);
    request_t r;
    r.kind = k;
    r.size = sz;
    r.addr = ad;
    pending_reqs.push_back(r);
    expected_rsps.push_back(allocator_step(r));
  endtask

  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // request driver
  int  drv_gap = 0;
  bit  drv_valid;
  request_t drv_item;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.kind <= 1'b0;
      req_if.request_size <= '0;
      req_if.block_address <= '0;
    end else begin
      drv_valid = req_if.valid && !req_if.ready;
      if (!drv_valid) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (pending_reqs.size() > 0) begin
          drv_item = pending_reqs.pop_front();
          req_if.kind <= drv_item.kind;
          req_if.request_size <= drv_item.size;
          req_if.block_address <= drv_item.addr;
          drv_valid = 1'b1;
          drv_gap = pick_gap();
        end
      end
      req_if.valid <= drv_valid;
    end
  end

  // response monitor and checker
  int       mon_stall = 0;
  outcome_t mon_exp;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transfer: status %0d addr %h", rsp_if.status,
                     rsp_if.granted_address);
        end else begin
          mon_exp = expected_rsps.pop_front();
          n_checked++;
          if (rsp_if.status !== mon_exp.status ||
              rsp_if.granted_address !== mon_exp.addr) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch on transfer %0d: exp status %0d addr %h, got status %0d addr %h",
                       n_checked, mon_exp.status, mon_exp.addr, rsp_if.status,
                       rsp_if.granted_address);
          end
        end
      end
      if (mon_stall > 0) begin
        mon_stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        mon_stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic drain();
    while (expected_rsps.size() > 0 || pending_reqs.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegPoolBase) mir_base = val;
    else mir_size = val;
    tree_clear();
  endtask

  // directed corner cases for the current pool
  task automatic directed_burst();
    issue(KIND_ALLOC, 32'd0, $urandom);
    issue(KIND_ALLOC, mir_size, 32'd0);
    issue(KIND_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(KIND_ALLOC, mir_size - 1, 32'd0);
    issue(KIND_ALLOC, 32'd1, 32'd0);
    issue(KIND_FREE, 32'hFFFF_FFFF, mir_base + 32'd1);
    issue(KIND_FREE, 32'd0, mir_base);
    issue(KIND_FREE, 32'd0, mir_base);
    // deepest level, then fill up to exhaustion
    for (int i = 0; i < 6; i++) issue(KIND_ALLOC, 32'd1, 32'd0);
    issue(KIND_ALLOC, mir_size >> 1, 32'd0);
    issue(KIND_ALLOC, mir_size >> 1, 32'd0);
    issue(KIND_ALLOC, mir_size >> 1, 32'd0);
    while (live_blocks.size() > 0) issue(KIND_FREE, $urandom, live_blocks[0]);
  endtask

  // mostly well-formed alloc/free traffic on a random-content basis
  task automatic random_burst(int unsigned count);
    int unsigned roll;
    int unsigned lvl;
    logic [31:0] sz;
    logic [31:0] lo;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        lvl = $urandom_range(0, Levels + 3);
        sz = mir_size >> lvl;
        lo = (sz >> 1) + 1;
        if (sz == 0) sz = 1;
        if (lo > sz) lo = sz;
        issue(KIND_ALLOC, $urandom_range(sz, lo), $urandom);
      end else if (roll < 88 && live_blocks.size() > 0) begin
        issue(KIND_FREE, $urandom, live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
      end else if (roll < 94) begin
        issue(KIND_ALLOC, $urandom, $urandom);
      end else begin
        issue(KIND_FREE, $urandom, $urandom);
      end
    end
  endtask

  task automatic run_phase(logic [31:0] base, logic [31:0] size, int unsigned count);
    drain();
    write_reg(RegPoolBase, base);
    write_reg(RegPoolSize, size);
    directed_burst();
    random_burst(count / 2);
    // sender holds off until the block is empty
    drain();
    random_burst(count - count / 2);
  endtask

  initial begin
    mir_base = DefPoolBase;
    mir_size = DefPoolSize;
    tree_clear();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // reset configuration first
    directed_burst();
    random_burst(60);
    run_phase(32'hFFFF_F000, 32'd4096, 60);
    run_phase($urandom, 32'd2, 30);
    run_phase(32'd0, 32'hFFFF_FFFF, 60);
    run_phase(32'hFFFF_FFFF, 32'd1000, 60);
    run_phase($urandom, 32'd3, 30);
    run_phase(32'h8000_0000, 32'h0001_0000, 60);
    drain();
    $display("checked %0d responses over 7 pool settings", n_checked);
    $display("allocs %0d, frees %0d, bad size %0d, no fit %0d, unknown address %0d",
             n_alloc_ok, n_free_ok, n_bad, n_nofit, n_unknown);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("[buddy_block_allocator_unit] OK");
    end else begin
      $display("[buddy_block_allocator_unit] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000_000;
    $display("timeout with %0d responses outstanding", expected_rsps.size());
    $display("[buddy_block_allocator_unit] ERROR");
    $finish;
  end

endmodule
